// ----- rtl/kex_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and sequence tables for the key event encoder
package kex_pkg;

	localparam logic [7:0] ESC = 8'h1b;

	// one assembled byte sequence, up to eight bytes
	typedef struct packed {
		logic [7:0][7:0] bytes;
		logic [3:0]      len;
		logic            atomic;   // drop the utf-8 character when it does not fit
		logic            full_ovf; // FIFO full at a utf-8 start
	} seq_t;

	function automatic logic [7:0] fkey_num(input logic [2:0] i);
		logic [7:0] r;
		begin
			unique case (i)
				3'd0: r = 8'd15;
				3'd1: r = 8'd17;
				3'd2: r = 8'd18;
				3'd3: r = 8'd19;
				3'd4: r = 8'd20;
				3'd5: r = 8'd21;
				3'd6: r = 8'd23;
				default: r = 8'd24;
			endcase
			return r;
		end
	endfunction

	function automatic logic [3:0] fkey_mod(input logic [1:0] i);
		logic [3:0] r;
		begin
			unique case (i)
				2'd0: r = 4'd0;
				2'd1: r = 4'd2;
				2'd2: r = 4'd5;
				default: r = 4'd6;
			endcase
			return r;
		end
	endfunction

	// map a navigation scan code to its final code, zero when unknown
	function automatic logic [7:0] nav_code(input logic [7:0] sc);
		logic [7:0] r;
		begin
			unique case (sc)
				"H": r = "A";
				"P": r = "B";
				"K": r = "D";
				"M": r = "C";
				"R": r = "2";
				"S": r = "3";
				"G": r = "H";
				"O": r = "F";
				"I": r = "5";
				"Q": r = "6";
				default: r = 8'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic is_nav_vk(input logic [7:0] vk);
		return (vk == 8'h26) || (vk == 8'h28) || (vk == 8'h25) || (vk == 8'h27) ||
			(vk == 8'h24) || (vk == 8'h23) || (vk == 8'h2d) || (vk == 8'h2e) ||
			(vk == 8'h21) || (vk == 8'h22);
	endfunction

	// append one byte to a sequence
	function automatic seq_t push(input seq_t s, input logic [7:0] b);
		seq_t r;
		begin
			r = s;
			r.bytes[s.len[2:0]] = b;
			r.len = s.len + 4'd1;
			return r;
		end
	endfunction

	// ESC [ num? (; mod)? final, num always below thirty
	function automatic seq_t push_csi(input seq_t s, input logic [4:0] num,
		input logic [3:0] md, input logic [7:0] fin);
		seq_t r;
		logic [1:0] tens;
		logic [4:0] ones;
		begin
			// decimal digits by compare and subtract
			tens = (num >= 5'd20) ? 2'd2 : ((num >= 5'd10) ? 2'd1 : 2'd0);
			ones = num - ((num >= 5'd20) ? 5'd20 : ((num >= 5'd10) ? 5'd10 : 5'd0));
			r = push(s, ESC);
			r = push(r, "[");
			if (num >= 5'd10) r = push(r, 8'("0") + 8'(tens));
			if (num != 5'd0) r = push(r, 8'("0") + 8'(ones));
			if (md != 4'd0) begin
				r = push(r, ";");
				r = push(r, 8'("0") + 8'(md));
			end
			r = push(r, fin);
			return r;
		end
	endfunction

endpackage

// ----- rtl/kex_encode.sv -----
`timescale 1ns / 1ps
// translates one key event into its byte sequence
module kex_encode (
	input  logic              key_down,
	input  logic [15:0]       char_code,
	input  logic [7:0]        virtual_key,
	input  logic [7:0]        scan_code,
	input  logic              shift_held,
	input  logic              left_alt_held,
	input  logic              right_alt_held,
	input  logic              left_ctrl_held,
	input  logic              right_ctrl_held,
	input  logic              enhanced_flag,
	input  logic [1:0]        escape_mode,
	input  logic              fifo_empty,
	input  logic              fifo_full,
	output kex_pkg::seq_t     seq
);

	logic       dn, sh, la, ra, lc, rc, en, alt, ctrl, chz, nav;
	logic [7:0] vk, code, nc;
	logic [3:0] f, m, md;
	logic [2:0] m3;
	kex_pkg::seq_t s;

	always_comb begin
		s = '0;
		vk = virtual_key;
		dn = key_down; sh = shift_held; la = left_alt_held; ra = right_alt_held;
		lc = left_ctrl_held; rc = right_ctrl_held; en = enhanced_flag;
		chz = (char_code != 16'd0);
		code = 8'd0;
		f = 4'(vk - 8'h70);
		m3 = '0; m = '0; md = '0; nc = '0;
		// alt-code key release acts as a clean press
		if (!dn && vk == 8'h12 && chz) begin
			dn = 1'b1; sh = 1'b0; la = 1'b0; ra = 1'b0; lc = 1'b0; rc = 1'b0; en = 1'b0;
		end
		if (char_code > 16'h1f && (lc | rc)) begin
			lc = 1'b0; rc = 1'b0;
			if (ra) ra = 1'b0; else la = 1'b0;
		end
		alt = la | ra;
		ctrl = lc | rc;
		nav = kex_pkg::is_nav_vk(vk) | en;
		md = kex_pkg::fkey_mod({ctrl, sh});
		m3 = {ctrl, alt, sh};
		m = (m3 != 3'd0) ? 4'(m3) + 4'd1 : 4'd0;
		nc = kex_pkg::nav_code(scan_code);
		if (!dn || vk == 8'h11 || vk == 8'h10) begin
			s = '0;
		end else if (vk == 8'h12) begin
			if (chz) s.atomic = 1'b1;
		end else if (char_code == 16'd9 && fifo_empty && sh) begin
			s = kex_pkg::push_csi(s, 5'd0, 4'd0, "Z");
		end else if (vk >= 8'h70 && vk <= 8'h7b) begin
			if (alt) s = kex_pkg::push(s, kex_pkg::ESC);
			if (f < 4'd4) begin
				if (md == 4'd0) begin
					s = kex_pkg::push(s, kex_pkg::ESC);
					s = kex_pkg::push(s, "O");
					s = kex_pkg::push(s, 8'("P") + 8'(f));
				end else begin
					s = kex_pkg::push_csi(s, 5'd1, md, 8'("P") + 8'(f));
				end
			end else begin
				s = kex_pkg::push_csi(s, 5'(kex_pkg::fkey_num(3'(f - 4'd4))), md, "~");
			end
		end else if (vk == 8'h1b && escape_mode == 2'd1) begin
			s = kex_pkg::push(s, 8'h03);
		end else if (vk == 8'h1b && escape_mode == 2'd2) begin
			s = kex_pkg::push_csi(s, 5'd0, 4'd0, "M");
		end else if (chz) begin
			if (alt) s = kex_pkg::push(s, kex_pkg::ESC);
			s.atomic = 1'b1;
		end else if (nav) begin
			if (nc >= "0" && nc <= "9")
				s = kex_pkg::push_csi(s, 5'(nc - 8'("0")), m, "~");
			else if (nc != 8'd0)
				s = kex_pkg::push_csi(s, (m != 4'd0) ? 5'd1 : 5'd0, m, nc);
		end else if (ctrl) begin
			if (vk >= "A" && vk <= "Z") code = vk - 8'h40;
			else if (vk >= 8'hdb && vk <= 8'hdd) code = vk - 8'hc0;
			else if (vk == 8'h32) code = 8'h00;
			else if (vk == 8'h36) code = 8'h1e;
			else if (vk == 8'hbd) code = 8'h1f;
			else code = 8'hff;
			if (code != 8'hff) begin
				if (alt) s = kex_pkg::push(s, kex_pkg::ESC);
				s = kex_pkg::push(s, code);
			end
		end
		seq = s;
		seq.full_ovf = 1'b0;
		seq.atomic = 1'b0;
		// append the character in utf-8; prefix bytes sit before it
		if (s.atomic) begin
			if (fifo_full && s.len == 4'd0) begin
				seq.full_ovf = 1'b1;
			end else if (char_code < 16'h80) begin
				seq = kex_pkg::push(s, char_code[7:0]);
				seq.atomic = 1'b0;
			end else if (char_code < 16'h800) begin
				seq = kex_pkg::push(s, {3'b110, char_code[10:6]});
				seq = kex_pkg::push(seq, {2'b10, char_code[5:0]});
				seq.atomic = 1'b1;
			end else begin
				seq = kex_pkg::push(s, {4'b1110, char_code[15:12]});
				seq = kex_pkg::push(seq, {2'b10, char_code[11:6]});
				seq = kex_pkg::push(seq, {2'b10, char_code[5:0]});
				seq.atomic = 1'b1;
			end
			seq.full_ovf = seq.full_ovf;
		end
	end

endmodule

// ----- rtl/key_event_to_xterm_sequence.sv -----
`timescale 1ns / 1ps
// top level: event encoder, byte FIFO memory and write sequencer
//
// Input channel (valid/stall) carries one word per item: kind 0 is a key
// event that appends its xterm byte sequence to an internal byte FIFO;
// kind 1 pops one byte. Each item yields exactly one result word on the
// output channel (bytes_added, overflow, out_byte, out_valid).
// A key event writes its sequence (at most 8 bytes) one byte per cycle
// through the single write port of the FIFO memory, then the done state
// registers its result word. A read item passes the read state (address,
// registered memory read) and the done state, which sets its result.
// The input stalls until the sequencer is back in idle, and while a
// result word waits under out_stall; no further item starts until it
// is taken. escape_mode is to be written through cfg_we/cfg_data while
// idle; the block does not enforce this. Reset clears head, count,
// escape_mode (to delete-line) and all valid flags; FIFO contents are
// undefined until written.
module key_event_to_xterm_sequence #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        key_down,
	input  logic [15:0] char_code,
	input  logic [7:0]  virtual_key,
	input  logic [7:0]  scan_code,
	input  logic        shift_held,
	input  logic        left_alt_held,
	input  logic        right_alt_held,
	input  logic        left_ctrl_held,
	input  logic        right_ctrl_held,
	input  logic        enhanced_flag,
	output logic        result_valid,
	input  logic        out_stall,
	output logic [3:0]  bytes_added,
	output logic        overflow,
	output logic [7:0]  out_byte,
	output logic        out_valid
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WRITE = 4'b0010,
		ST_READ  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t        state_q;
	logic [1:0]    esc_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	kex_pkg::seq_t seq_q, seq_c, seq_w;
	logic [3:0]    idx_q, added_q, tail_c;
	logic          ovf_q, full_c, empty_c, take, drop_c;
	logic [7:0]    mem [FIFO_DEPTH];
	logic [7:0]    rd_q;
	logic          rdv_q;
	logic [CW-1:0] room;
	logic [AW:0]   wsum;
	logic [AW-1:0] waddr;

	assign empty_c = (count_q == '0);
	assign full_c  = (count_q == CW'(FIFO_DEPTH));
	assign room    = CW'(FIFO_DEPTH) - count_q;
	assign take    = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (result_valid && out_stall);

	kex_encode u_enc (
		.key_down, .char_code, .virtual_key, .scan_code, .shift_held,
		.left_alt_held, .right_alt_held, .left_ctrl_held, .right_ctrl_held,
		.enhanced_flag, .escape_mode(esc_q), .fifo_empty(empty_c),
		.fifo_full(full_c), .seq(seq_c)
	);

	// whole utf-8 character is dropped when it does not fit, prefix stays
	always_comb begin
		seq_w  = seq_c;
		tail_c = (seq_c.bytes[seq_c.len[2:0] - 3'd1][7:6] == 2'b10 &&
			seq_c.bytes[seq_c.len[2:0] - 3'd2][7:6] == 2'b10) ? 4'd3 : 4'd2;
		drop_c = seq_c.atomic && (room < CW'(seq_c.len));
		if (drop_c) seq_w.len = seq_c.len - tail_c;
	end

	assign wsum  = {1'b0, head_q} + (AW + 1)'(count_q);
	assign waddr = (wsum >= (AW + 1)'(FIFO_DEPTH)) ?
		AW'(wsum - (AW + 1)'(FIFO_DEPTH)) : AW'(wsum);

	// fifo memory: one byte written per cycle, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && idx_q < seq_q.len && !full_c)
			mem[waddr] <= seq_q.bytes[idx_q[2:0]];
		rd_q <= mem[head_q];
	end

	// sequencer and fifo pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			esc_q        <= 2'd2;
			head_q       <= '0;
			count_q      <= '0;
			result_valid <= 1'b0;
			idx_q        <= '0;
			added_q      <= '0;
			ovf_q        <= 1'b0;
			rdv_q        <= 1'b0;
			seq_q        <= '0;
			bytes_added  <= '0;
			overflow     <= 1'b0;
			out_byte     <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) esc_q <= cfg_data;
			if (result_valid && !out_stall && state_q != ST_DONE) result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						idx_q   <= '0;
						added_q <= '0;
						rdv_q   <= 1'b0;
						if (kind) begin
							state_q <= ST_READ;
							ovf_q   <= 1'b0;
						end else begin
							state_q <= ST_WRITE;
							seq_q   <= seq_w;
							ovf_q   <= seq_c.full_ovf | drop_c;
						end
					end
				end
				ST_WRITE: begin
					if (idx_q < seq_q.len) begin
						idx_q <= idx_q + 4'd1;
						if (full_c) ovf_q <= 1'b1;
						else begin
							count_q <= count_q + CW'(1);
							added_q <= added_q + 4'd1;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
					if (!empty_c) begin
						rdv_q   <= 1'b1;
						count_q <= count_q - CW'(1);
						head_q  <= (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (!result_valid || !out_stall) begin
						result_valid <= 1'b1;
						bytes_added  <= added_q;
						overflow     <= ovf_q;
						out_byte     <= rdv_q ? rd_q : 8'd0;
						out_valid    <= rdv_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/kex_checker.sv -----
`timescale 1ns / 1ps
// port-level checker bound to the top level
module kex_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       result_valid,
	input logic       out_stall,
	input logic [3:0] bytes_added,
	input logic       overflow,
	input logic [7:0] out_byte,
	input logic       out_valid
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_stall |=> result_valid && $stable(out_byte))
		else $error("result changed under stall");

	// a read result never reports appended bytes
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_valid |-> bytes_added == 4'd0 && !overflow)
		else $error("read result with key fields");

	// a key sequence never exceeds eight bytes
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> bytes_added <= 4'd8)
		else $error("too many bytes");

	// an accepted word is followed by a stall
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted back to back");

endmodule

bind key_event_to_xterm_sequence kex_checker u_kex_checker (
	.clk, .arst_n, .in_valid, .in_stall, .result_valid, .out_stall,
	.bytes_added, .overflow, .out_byte, .out_valid
);
